/* rtl/mxt_pkg.sv */
// ----------------------------------------------------------------------------
// mxt_pkg
// Shared constants, types and engine states for the max-XOR-pair trie block.
// ----------------------------------------------------------------------------
package mxt_pkg;

	localparam int VALUE_BITS  = 32;
	localparam int NODE_COUNT  = 32768;
	localparam int NODE_W      = $clog2(NODE_COUNT);
	localparam int CNT_W       = NODE_W + 1;
	localparam int LVL_W       = $clog2(VALUE_BITS);
	localparam int DATA_W      = 32;
	localparam int IN_TDATA_W  = DATA_W;
	localparam int OUT_TDATA_W = 2 * DATA_W;

	// job queue between front and engine; depth must be a power of two
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// [1] = child for bit 1, [0] = child for bit 0; zero means no child
	typedef logic [1:0][NODE_W-1:0] links_t;

	typedef struct packed {
		logic                  clear;
		logic [VALUE_BITS-1:0] value;
	} job_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] best;
		logic [VALUE_BITS-1:0] maxv;
		logic                  full;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_ROOT,
		ST_INS_WALK,
		ST_INS_ALLOC,
		ST_QRY_ROOT,
		ST_QRY_WALK,
		ST_DONE
	} state_t;

endpackage

/* rtl/max_xor_pair_trie.sv */
// Timing: each input beat is queued in the front, then the engine pops it, walks the trie
// level by level for the insert, walks it again for the query and registers the result;
// a full pool skips the insert walk. The engine works on one job at a time, while the
// front queue accepts new beats until it fills.
// Reset: trie empty (root links null, node 1 next free), running max zero;
// the node memory needs no clearing pass, nodes are written when allocated.
// ----------------------------------------------------------------------------
// max_xor_pair_trie
// Streaming maximum-XOR-pair search over a binary trie in a node pool.
// ----------------------------------------------------------------------------
module max_xor_pair_trie import mxt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] value
	input  logic [0:0]             s_tuser,   // [0] clear_first
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] best_xor, [63:32] running_max
	output logic [0:0]             m_tuser    // [0] pool_full
);

	logic    job_valid;
	job_t    job;
	logic    job_pop;
	result_t res;

	mxt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	mxt_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.res_valid (m_tvalid),
		.res       (res),
		.res_ready (m_tready)
	);

	assign m_tdata = {DATA_W'(res.maxv), DATA_W'(res.best)};
	assign m_tuser = res.full;

endmodule

/* rtl/mxt_front.sv */
// ----------------------------------------------------------------------------
// mxt_front
// Input side: takes beats, turns each into a job and queues them for the engine.
// ----------------------------------------------------------------------------
module mxt_front import mxt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,   // [31:0] value
	input  logic [0:0]            s_tuser,   // [0] clear_first
	output logic                  job_valid,
	output job_t                  job,
	input  logic                  job_pop
);

	job_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;
	job_t              in_job;

	assign s_tready  = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push      = s_tvalid && s_tready;
	assign pop       = job_pop && job_valid;
	assign job_valid = (count_q != '0);
	assign job       = queue_q[rd_ptr_q];

	always_comb begin
		in_job.value = s_tdata[VALUE_BITS-1:0];
		in_job.clear = s_tuser[0];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

/* rtl/mxt_engine.sv */
// ----------------------------------------------------------------------------
// mxt_engine
// Trie engine: node pool memory, insert walk, greedy XOR query, result register.
// ----------------------------------------------------------------------------
module mxt_engine import mxt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_valid,
	input  job_t    job,
	output logic    job_pop,
	output logic    res_valid,
	output result_t res,
	input  logic    res_ready
);

	localparam logic [CNT_W-1:0] FULL_AT = CNT_W'(NODE_COUNT - VALUE_BITS);
	localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(VALUE_BITS - 1);

	links_t mem [NODE_COUNT];
	links_t rd_q;

	state_t                state_q, state_d;
	logic [CNT_W-1:0]      nfree_q, nfree_d;
	links_t                root_q, root_d;
	logic [VALUE_BITS-1:0] max_q, max_d;
	logic [VALUE_BITS-1:0] val_q, val_d;
	logic [VALUE_BITS-1:0] acc_q, acc_d;
	logic [LVL_W-1:0]      lvl_q, lvl_d;
	logic [NODE_W-1:0]     node_q, node_d;
	logic                  full_q, full_d;
	logic                  out_valid_q;
	result_t               out_q;

	logic              mem_we;
	logic [NODE_W-1:0] mem_wa;
	links_t            mem_wd;
	logic [NODE_W-1:0] mem_ra;
	logic              out_load;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	always_comb begin
		logic              cur_bit;
		logic              nxt_bit;
		logic [LVL_W-1:0]  lvl_dec;
		logic [NODE_W-1:0] fresh;
		links_t            qlinks;
		links_t            wlinks;
		logic [NODE_W-1:0] opp_link;
		logic [NODE_W-1:0] same_link;
		logic [NODE_W-1:0] nxt_node;
		logic              found;

		cur_bit   = val_q[lvl_q];
		lvl_dec   = lvl_q - LVL_W'(1);
		nxt_bit   = val_q[lvl_dec];
		fresh     = nfree_q[NODE_W-1:0];
		qlinks    = (state_q == ST_QRY_ROOT) ? root_q : rd_q;
		opp_link  = qlinks[~cur_bit];
		same_link = qlinks[cur_bit];
		wlinks    = '0;
		nxt_node  = '0;
		found     = 1'b0;

		state_d  = state_q;
		nfree_d  = nfree_q;
		root_d   = root_q;
		max_d    = max_q;
		val_d    = val_q;
		acc_d    = acc_q;
		lvl_d    = lvl_q;
		node_d   = node_q;
		full_d   = full_q;
		mem_we   = 1'b0;
		mem_wa   = '0;
		mem_wd   = '0;
		mem_ra   = '0;
		job_pop  = 1'b0;
		out_load = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					val_d   = job.value;
					acc_d   = '0;
					lvl_d   = TOP_LVL;
					if (job.clear) begin
						nfree_d = CNT_W'(1);
						root_d  = '0;
						max_d   = '0;
					end
					state_d = ST_INS_ROOT;
				end
			end
			ST_INS_ROOT: begin
				full_d = (nfree_q > FULL_AT);
				if (nfree_q > FULL_AT) begin
					state_d = ST_QRY_ROOT;
				end else if (root_q[cur_bit] != '0) begin
					node_d  = root_q[cur_bit];
					mem_ra  = root_q[cur_bit];
					lvl_d   = lvl_dec;
					state_d = ST_INS_WALK;
				end else begin
					root_d[cur_bit] = fresh;
					state_d         = ST_INS_ALLOC;
				end
			end
			ST_INS_WALK: begin
				if (rd_q[cur_bit] != '0) begin
					if (lvl_q == '0) begin
						lvl_d   = TOP_LVL;
						state_d = ST_QRY_ROOT;
					end else begin
						node_d = rd_q[cur_bit];
						mem_ra = rd_q[cur_bit];
						lvl_d  = lvl_dec;
					end
				end else begin
					// missing branch: hook the first fresh node onto this node
					wlinks          = rd_q;
					wlinks[cur_bit] = fresh;
					mem_we          = 1'b1;
					mem_wa          = node_q;
					mem_wd          = wlinks;
					state_d         = ST_INS_ALLOC;
				end
			end
			ST_INS_ALLOC: begin
				// fresh nodes form a chain: each but the last points at the next one
				if (lvl_q != '0) begin
					wlinks[nxt_bit] = fresh + NODE_W'(1);
				end
				mem_we  = 1'b1;
				mem_wa  = fresh;
				mem_wd  = wlinks;
				nfree_d = nfree_q + CNT_W'(1);
				if (lvl_q == '0) begin
					lvl_d   = TOP_LVL;
					state_d = ST_QRY_ROOT;
				end else begin
					lvl_d = lvl_dec;
				end
			end
			ST_QRY_ROOT, ST_QRY_WALK: begin
				if (opp_link != '0) begin
					acc_d[lvl_q] = 1'b1;
					nxt_node     = opp_link;
					found        = 1'b1;
				end else if (same_link != '0) begin
					nxt_node = same_link;
					found    = 1'b1;
				end
				if (!found) begin
					acc_d   = '0;
					state_d = ST_DONE;
				end else if (lvl_q == '0) begin
					state_d = ST_DONE;
				end else begin
					mem_ra  = nxt_node;
					lvl_d   = lvl_dec;
					state_d = ST_QRY_WALK;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || res_ready) begin
					out_load = 1'b1;
					max_d    = (acc_q > max_q) ? acc_q : max_q;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nfree_q     <= CNT_W'(1);
			root_q      <= '0;
			max_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			nfree_q <= nfree_d;
			root_q  <= root_d;
			max_q   <= max_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		val_q  <= val_d;
		acc_q  <= acc_d;
		lvl_q  <= lvl_d;
		node_q <= node_d;
		full_q <= full_d;
		if (out_load) begin
			out_q.best <= acc_q;
			out_q.maxv <= max_d;
			out_q.full <= full_q;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

/* rtl/mxt_checker.sv */
// ----------------------------------------------------------------------------
// mxt_checker
// Port-level checks for the max-XOR-pair trie block, bound to the top level.
// ----------------------------------------------------------------------------
module mxt_checker import mxt_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [0:0]             m_tuser
);

	// stalled result beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// running max covers this beat's best xor
	a_max_ge_best: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:DATA_W] >= m_tdata[DATA_W-1:0])
		else $error("running max below best xor");

	// a full pool holds at least two distinct values, so some pair differs
	a_full_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[DATA_W-1:0] != '0)
		else $error("pool full but best xor is zero");

endmodule

bind max_xor_pair_trie mxt_checker u_mxt_checker (.*);
